>>> design/shg_pkg.sv
// Shared types and constants for the horizontal Sobel gradient block.
`timescale 1ns / 1ps

package shg_pkg;

   // Request command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Fixed field widths
   localparam int GRAD_BITS  = 11;
   localparam int SIZE_BITS  = 11;
   localparam int SIZE_MIN   = 3;
   localparam int SIZE_RESET = 512;

   // One result as it sits in the output buffer
   typedef struct packed {
      logic signed [GRAD_BITS-1:0] gradient;
      logic                        frame_last;
   } shg_result_type;

endpackage

>>> design/shg_req_if.sv
// Request channel: one pixel or drain tick per request.
`timescale 1ns / 1ps

interface shg_req_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [PIXEL_BITS-1:0] pixel_value;

   modport source (output valid, output command, output pixel_value, input ready);
   modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

>>> design/shg_rsp_if.sv
// Result channel: at most one signed gradient per request.
`timescale 1ns / 1ps

interface shg_rsp_if;
   import shg_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [GRAD_BITS-1:0] gradient;
   logic                        frame_last;

   modport source (output valid, output gradient, output frame_last, input ready);
   modport sink   (input valid, input gradient, input frame_last, output ready);
endinterface

>>> design/shg_csr_if.sv
// Configuration write channel carrying the image size.
`timescale 1ns / 1ps

interface shg_csr_if;
   import shg_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SIZE_BITS-1:0] image_size;

   modport source (output valid, output image_size, input ready);
   modport sink   (input valid, input image_size, output ready);
endinterface

>>> design/shg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module shg_ram #(
   parameter int  WIDTH     = 16,
   parameter int  DEPTH     = 1024,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/shg_out_fifo.sv
// Two-entry output buffer that drives the result channel.
`timescale 1ns / 1ps

module shg_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  shg_pkg::shg_result_type push_data,
   output logic                   full,
   shg_rsp_if.source              rsp_chan
);
   import shg_pkg::*;

   shg_result_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign full = (count_ff == 2'd2);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.gradient   = entry_ff[rd_ptr_ff].gradient;
   assign rsp_chan.frame_last = entry_ff[rd_ptr_ff].frame_last;

endmodule

>>> design/sobel_horizontal_gradient_top.sv
// Top level of the streaming horizontal Sobel gradient block.
`timescale 1ns / 1ps

// Streaming 3x3 horizontal Sobel gradient over a square image sent in raster
// order. It takes one request per clock while ready is high: each pixel request
// is handled in the cycle it is accepted, and its result, if any, is visible on
// the result channel from the next cycle through a two-entry output buffer, so
// requests keep flowing while one result waits. A result for pixel (r,c) leaves
// when pixel (r+1,c+1) is accepted; drain requests flush the tail of a finished
// frame one result each. The two line buffers share one RAM with a registered
// read port that is addressed with the next input column, so the stored rows are
// ready when the pixel arrives. Border pixels give zero and the last result of a
// frame carries frame_last. A write of image_size (clamped to 3..MAX_SIZE)
// restarts the frame; line buffer contents need no clearing after reset.
module sobel_horizontal_gradient_top #(
   parameter int MAX_SIZE   = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   shg_req_if.sink   req_chan,
   shg_rsp_if.source rsp_chan,
   shg_csr_if.sink   csr_chan
);
   import shg_pkg::*;

   localparam int CW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int PW  = $clog2(MAX_SIZE + 2);
   localparam int SW  = (PIXEL_BITS + 3 > GRAD_BITS) ? PIXEL_BITS + 3 : GRAD_BITS;
   localparam int RESET_SIDE = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

   // Configuration and position state
   logic [CW-1:0] side_m1_ff, side_m1_in;
   logic [PW-1:0] side_p1_ff, side_p1_in;
   logic [CW-1:0] in_row_ff, in_row_in, in_col_ff, in_col_in;
   logic [CW-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [2:0][2:0][PIXEL_BITS-1:0] win_ff, win_in;

   logic                      cfg_write, accept, is_pixel, emit, pos_lt, border;
   logic [31:0]               size_clamp;
   logic [2*PIXEL_BITS-1:0]   line_q;
   logic [PIXEL_BITS-1:0]     top_px, mid_px;
   logic [2:0][PIXEL_BITS-1:0] right_px, left_px;
   logic [SW-1:0]             d0, d1, d2, grad_sum;
   logic                      fifo_full;
   shg_result_type            result;

   assign cfg_write      = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_pixel       = (req_chan.command == CMD_PIXEL);

   // Line buffers: upper row in the high half, middle row in the low half
   shg_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_SIZE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && is_pixel && !cfg_write),
      .wr_addr (in_col_ff),
      .wr_data ({mid_px, req_chan.pixel_value}),
      .rd_addr (in_col_in),
      .rd_data (line_q)
   );

   assign top_px = line_q[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_px = line_q[PIXEL_BITS-1:0];

   // Clamp the written size
   always_comb begin
      size_clamp = {{(32 - SIZE_BITS){1'b0}}, csr_chan.image_size};
      if (size_clamp < 32'(SIZE_MIN)) begin
         size_clamp = 32'(SIZE_MIN);
      end
      if (size_clamp > 32'(MAX_SIZE)) begin
         size_clamp = 32'(MAX_SIZE);
      end
      side_m1_in = cfg_write ? CW'(size_clamp - 32'd1) : side_m1_ff;
      side_p1_in = cfg_write ? PW'(size_clamp + 32'd1) : side_p1_ff;
   end

   // Drain emits only once the input has wrapped past the output frame
   assign pos_lt = (in_row_ff < out_row_ff) ||
                   ((in_row_ff == out_row_ff) && (in_col_ff < out_col_ff));

   assign emit = accept && (is_pixel ? (pend_ff == side_p1_ff) : pos_lt);

   // Window columns that feed the gradient
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         right_px[r] = is_pixel ? win_ff[r][1] : win_ff[r][2];
         left_px[r]  = is_pixel ? win_ff[r][1] : win_ff[r][0];
      end
      right_px[0] = is_pixel ? top_px : win_ff[0][2];
      right_px[1] = is_pixel ? mid_px : win_ff[1][2];
      right_px[2] = is_pixel ? req_chan.pixel_value : win_ff[2][2];
      left_px[0]  = is_pixel ? win_ff[0][1] : win_ff[0][0];
      left_px[1]  = is_pixel ? win_ff[1][1] : win_ff[1][0];
      left_px[2]  = is_pixel ? win_ff[2][1] : win_ff[2][0];
   end

   // Weighted column difference, wrapped to the result width
   assign d0       = SW'(right_px[0]) - SW'(left_px[0]);
   assign d1       = SW'(right_px[1]) - SW'(left_px[1]);
   assign d2       = SW'(right_px[2]) - SW'(left_px[2]);
   assign grad_sum = d0 + {d1[SW-2:0], 1'b0} + d2;

   assign border = (out_row_ff == '0) || (out_row_ff == side_m1_ff) ||
                   (out_col_ff == '0) || (out_col_ff == side_m1_ff);

   always_comb begin
      result.gradient   = border ? '0 : grad_sum[GRAD_BITS-1:0];
      result.frame_last = (out_row_ff == side_m1_ff) && (out_col_ff == side_m1_ff);
   end

   // Advance counters and shift the window
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      pend_in    = pend_ff;
      win_in     = win_ff;
      if (cfg_write) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         pend_in    = '0;
         win_in     = '0;
      end else if (accept) begin
         if (is_pixel) begin
            for (int r = 0; r < 3; r++) begin
               win_in[r][0] = win_ff[r][1];
               win_in[r][1] = win_ff[r][2];
            end
            win_in[0][2] = top_px;
            win_in[1][2] = mid_px;
            win_in[2][2] = req_chan.pixel_value;
            if (in_col_ff == side_m1_ff) begin
               in_col_in = '0;
               in_row_in = (in_row_ff == side_m1_ff) ? '0 : in_row_ff + CW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            if (!emit) begin
               pend_in = pend_ff + PW'(1);
            end
         end else if (emit) begin
            pend_in = pend_ff - PW'(1);
         end
         if (emit) begin
            if (out_col_ff == side_m1_ff) begin
               out_col_in = '0;
               out_row_in = (out_row_ff == side_m1_ff) ? '0 : out_row_ff + CW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff <= CW'(RESET_SIDE - 1);
         side_p1_ff <= PW'(RESET_SIDE + 1);
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         pend_ff    <= '0;
         win_ff     <= '0;
      end else begin
         side_m1_ff <= side_m1_in;
         side_p1_ff <= side_p1_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         pend_ff    <= pend_in;
         win_ff     <= win_in;
      end
   end

   // Queue results toward the result channel
   shg_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit && !cfg_write),
      .push_data (result),
      .full      (fifo_full),
      .rsp_chan  (rsp_chan)
   );

endmodule
